/* hdl/tshtlv_pkg.sv */
// Shared types, constants and a helper function for the trace-set header TLV parser.
// Used by tshtlv_core, the top level trace_set_header_tlv_parser and tshtlv_checker.
// Depends on nothing else.
package tshtlv_pkg;

  localparam int unsigned MAX_VALUE_LEN = 255;
  localparam int unsigned VLEFT_W = $clog2(MAX_VALUE_LEN + 1);

  localparam logic [6:0] LEN_LONG_MASK = 7'h7F;
  localparam logic [7:0] TAG_TRACES  = 8'h41;
  localparam logic [7:0] TAG_SAMPLES = 8'h42;
  localparam logic [7:0] TAG_CODING  = 8'h43;
  localparam logic [7:0] TAG_DATA    = 8'h44;
  localparam logic [7:0] TAG_TITLE   = 8'h45;
  localparam logic [7:0] TAG_STR0    = 8'h46;
  localparam logic [7:0] TAG_STR1    = 8'h47;
  localparam logic [7:0] TAG_STR2    = 8'h49;
  localparam logic [7:0] TAG_STR3    = 8'h4A;
  localparam logic [7:0] TAG_BYTES   = 8'h59;
  localparam logic [7:0] TAG_END     = 8'h5F;
  localparam logic [7:0] TAG_MAX     = 8'h75;

  localparam logic [2:0] MAX_NUM_BYTES = 3'd4;
  localparam logic [3:0] CODING_SIZE_MASK = 4'hF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_TAG = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] crypto_data_bytes;
    logic [31:0] title_bytes;
    logic [7:0]  sample_format;
    logic [31:0] samples_per_trace;
    logic [31:0] trace_count;
    logic [31:0] bytes_per_trace;
    logic [7:0]  record_length;
    logic [31:0] record_value;
    logic [7:0]  record_tag;
    status_t     status;
    logic        header_done;
  } rec_t;

  function automatic logic is_numeric(input logic [7:0] tag);
    return !(tag == TAG_STR0 || tag == TAG_STR1 || tag == TAG_STR2 ||
             tag == TAG_STR3 || tag == TAG_BYTES);
  endfunction

endpackage

/* hdl/tshtlv_core.sv */
// Parse state machine and captured header fields of the TLV parser.
// Takes one header byte per step and forms the result word of a completed or rejected record.
// Depends on tshtlv_pkg.
module tshtlv_core import tshtlv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       start_flag,
  output logic       rec_valid,
  output rec_t       rec
);

  typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_LENEXT, PH_VALUE} phase_t;

  phase_t             phase, phase_next;
  logic               stopped, stopped_next;
  logic [7:0]         current_tag, current_tag_next;
  logic [2:0]         len_left, len_left_next;
  logic [31:0]        len_acc, len_acc_next;
  logic [VLEFT_W-1:0] val_left, val_left_next;
  logic [2:0]         byte_idx, byte_idx_next;
  logic [31:0]        val_acc, val_acc_next;
  logic [31:0]        count_store, count_next;
  logic [31:0]        samples_store, samples_next;
  logic [7:0]         coding_store, coding_next;
  logic [31:0]        title_store, title_next;
  logic [31:0]        data_store, data_next;
  logic [4:0]         seen, seen_next;

  phase_t             ph_c;
  logic               stp_c;
  logic [7:0]         tag_c;
  logic [2:0]         len_left_c;
  logic [31:0]        len_acc_c;
  logic [VLEFT_W-1:0] val_left_c;
  logic [2:0]         idx_c;
  logic [31:0]        val_acc_c;
  logic [31:0]        count_c, samples_c, title_c, data_c;
  logic [7:0]         coding_c;
  logic [4:0]         seen_c;

  logic               do_begin, do_finish, do_fail;
  logic [31:0]        begin_len, fin_raw, acc_byte, acc_new, prod;
  logic [7:0]         fail_tag;
  status_t            fail_status;
  logic [2:0]         idx_inc;

  always_comb begin
    // A start byte sees the state as it is after reset.
    ph_c       = start_flag ? PH_TAG : phase;
    stp_c      = start_flag ? 1'b0 : stopped;
    tag_c      = start_flag ? '0 : current_tag;
    len_left_c = start_flag ? '0 : len_left;
    len_acc_c  = start_flag ? '0 : len_acc;
    val_left_c = start_flag ? '0 : val_left;
    idx_c      = start_flag ? '0 : byte_idx;
    val_acc_c  = start_flag ? '0 : val_acc;
    count_c    = start_flag ? '0 : count_store;
    samples_c  = start_flag ? '0 : samples_store;
    coding_c   = start_flag ? '0 : coding_store;
    title_c    = start_flag ? '0 : title_store;
    data_c     = start_flag ? '0 : data_store;
    seen_c     = start_flag ? '0 : seen;

    phase_next       = ph_c;
    stopped_next     = stp_c;
    current_tag_next = tag_c;
    len_left_next    = len_left_c;
    len_acc_next     = len_acc_c;
    val_left_next    = val_left_c;
    byte_idx_next    = idx_c;
    val_acc_next     = val_acc_c;
    count_next       = count_c;
    samples_next     = samples_c;
    coding_next      = coding_c;
    title_next       = title_c;
    data_next        = data_c;
    seen_next        = seen_c;

    do_begin    = 1'b0;
    do_finish   = 1'b0;
    do_fail     = 1'b0;
    begin_len   = '0;
    fin_raw     = '0;
    fail_tag    = tag_c;
    fail_status = ST_OK;
    idx_inc     = (idx_c < MAX_NUM_BYTES) ? idx_c + 3'd1 : idx_c;
    acc_byte    = (idx_c < MAX_NUM_BYTES) ? ({24'b0, data_byte} << {idx_c[1:0], 3'b000}) : '0;
    acc_new     = '0;
    prod        = samples_c * {28'b0, coding_c[3:0] & CODING_SIZE_MASK};

    rec_valid       = 1'b0;
    rec             = '0;

    if (!stp_c) begin
      unique case (ph_c)
        PH_TAG: begin
          if (data_byte > TAG_MAX) begin
            do_fail     = 1'b1;
            fail_tag    = data_byte;
            fail_status = ST_BAD_TAG;
          end else begin
            current_tag_next = data_byte;
            phase_next       = PH_LEN;
          end
        end
        PH_LEN: begin
          if (data_byte[7]) begin
            if ((data_byte[6:0] & LEN_LONG_MASK) > 7'(MAX_NUM_BYTES)) begin
              do_fail     = 1'b1;
              fail_status = ST_BAD_LEN;
            end else if (data_byte[6:0] == '0) begin
              do_begin = 1'b1;
            end else begin
              len_left_next = data_byte[2:0];
              len_acc_next  = '0;
              byte_idx_next = '0;
              phase_next    = PH_LENEXT;
            end
          end else begin
            do_begin  = 1'b1;
            begin_len = {24'b0, data_byte};
          end
        end
        PH_LENEXT: begin
          acc_new       = len_acc_c | acc_byte;
          len_acc_next  = acc_new;
          byte_idx_next = idx_inc;
          len_left_next = len_left_c - 3'd1;
          if (len_left_c == 3'd1) begin
            do_begin  = 1'b1;
            begin_len = acc_new;
          end
        end
        PH_VALUE: begin
          acc_new       = val_acc_c | acc_byte;
          val_acc_next  = acc_new;
          byte_idx_next = idx_inc;
          val_left_next = val_left_c - VLEFT_W'(1);
          if (val_left_c == VLEFT_W'(1)) begin
            do_finish = 1'b1;
            fin_raw   = acc_new;
          end
        end
        default: begin
          phase_next = PH_TAG;
        end
      endcase
    end

    if (do_begin) begin
      len_acc_next = begin_len;
      if (begin_len > 32'(MAX_VALUE_LEN)) begin
        do_fail     = 1'b1;
        fail_status = ST_BAD_LEN;
      end else if (is_numeric(tag_c) && begin_len > 32'(MAX_NUM_BYTES)) begin
        do_fail     = 1'b1;
        fail_status = ST_BAD_LEN;
      end else begin
        val_acc_next  = '0;
        byte_idx_next = '0;
        if (begin_len == '0) begin
          do_finish = 1'b1;
          fin_raw   = '0;
        end else begin
          val_left_next = begin_len[VLEFT_W-1:0];
          phase_next    = PH_VALUE;
        end
      end
    end

    if (do_finish) begin
      rec_valid          = 1'b1;
      rec.record_tag     = tag_c;
      rec.record_value   = is_numeric(tag_c) ? fin_raw : '0;
      rec.record_length  = len_acc_next[7:0];
      rec.status         = ST_OK;
      phase_next         = PH_TAG;
      case (tag_c)
        TAG_TRACES:  begin count_next   = rec.record_value;      seen_next[0] = 1'b1; end
        TAG_SAMPLES: begin samples_next = rec.record_value;      seen_next[1] = 1'b1; end
        TAG_CODING:  begin coding_next  = rec.record_value[7:0]; seen_next[2] = 1'b1; end
        TAG_DATA:    begin data_next    = rec.record_value;      seen_next[3] = 1'b1; end
        TAG_TITLE:   begin title_next   = rec.record_value;      seen_next[4] = 1'b1; end
        default:     begin end
      endcase
      if (tag_c == TAG_END) begin
        rec.header_done = 1'b1;
        stopped_next    = 1'b1;
        if (&seen_c) begin
          rec.bytes_per_trace = prod + data_c + title_c;
        end else begin
          rec.status = ST_MISSING;
        end
      end
    end

    if (do_fail) begin
      rec_valid       = 1'b1;
      rec.record_tag  = fail_tag;
      rec.header_done = 1'b1;
      rec.status      = fail_status;
      stopped_next    = 1'b1;
      phase_next      = PH_TAG;
    end

    rec.trace_count       = count_next;
    rec.samples_per_trace = samples_next;
    rec.sample_format     = coding_next;
    rec.title_bytes       = title_next;
    rec.crypto_data_bytes = data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG;
      stopped       <= 1'b0;
      current_tag   <= '0;
      len_left      <= '0;
      len_acc       <= '0;
      val_left      <= '0;
      byte_idx      <= '0;
      val_acc       <= '0;
      count_store   <= '0;
      samples_store <= '0;
      coding_store  <= '0;
      title_store   <= '0;
      data_store    <= '0;
      seen          <= '0;
    end else if (step) begin
      phase         <= phase_next;
      stopped       <= stopped_next;
      current_tag   <= current_tag_next;
      len_left      <= len_left_next;
      len_acc       <= len_acc_next;
      val_left      <= val_left_next;
      byte_idx      <= byte_idx_next;
      val_acc       <= val_acc_next;
      count_store   <= count_next;
      samples_store <= samples_next;
      coding_store  <= coding_next;
      title_store   <= title_next;
      data_store    <= data_next;
      seen          <= seen_next;
    end
  end

endmodule

/* hdl/trace_set_header_tlv_parser.sv */
// Top level of the trace-set header TLV parser: input register, parser core, result register.
// Depends on tshtlv_pkg and tshtlv_core.
//
// The slave stream carries one header byte per word in s_axis_tdata, with s_axis_tuser set on
// the first byte of a header; that byte clears all parse state and captured fields. The master
// stream gives one word for each completed record, for a rejected tag or length, and for the
// end tag, which closes the header and carries the computed bytes per trace.
// A byte is taken into the input register and parsed from there once the result register
// is free; its result word, if any, is loaded into the result register, which drives
// m_axis_tvalid. One byte is taken every cycle while the master stream is not stalled;
// the per-byte parse step is a single pass through the core.
// When the receiver holds m_axis_tready low with a word waiting, one more byte is held in the
// input register and s_axis_tready falls until the word is taken.
// After the header closes or an error is flagged, bytes are taken and dropped without result
// until a byte with s_axis_tuser set starts a new header.
// Reset empties both registers and returns the parser to its initial state.
module trace_set_header_tlv_parser import tshtlv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // data_byte
  input  logic [0:0]   s_axis_tuser,  // start_flag
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // record_tag, record_value, record_length, bytes_per_trace, trace_count,
  // samples_per_trace, sample_format, title_bytes, crypto_data_bytes
  output logic [215:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser   // header_done, status
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       out_free;
  logic       step;
  logic       rec_valid;
  rec_t       rec;
  rec_t       out_rec;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser[0];
    end
  end

  tshtlv_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (in_byte),
    .start_flag (in_start),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= step && rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && rec_valid && out_free) begin
      out_rec <= rec;
    end
  end

  assign m_axis_tdata = {out_rec.crypto_data_bytes, out_rec.title_bytes, out_rec.sample_format,
                         out_rec.samples_per_trace, out_rec.trace_count, out_rec.bytes_per_trace,
                         out_rec.record_length, out_rec.record_value, out_rec.record_tag};
  assign m_axis_tuser = {out_rec.status, out_rec.header_done};

endmodule

/* hdl/tshtlv_checker.sv */
// Port-level assertions for trace_set_header_tlv_parser and the bind that attaches them.
// Depends on tshtlv_pkg.
module tshtlv_checker import tshtlv_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [215:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word present right after reset");

  a_error_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2:1] != ST_OK |-> m_axis_tuser[0])
    else $error("error status without header done");

  a_tlen_only_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[79:48] != '0 |-> m_axis_tuser[0]
      && m_axis_tuser[2:1] == ST_OK)
    else $error("trace length outside a successful header end");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind trace_set_header_tlv_parser tshtlv_checker u_tshtlv_checker (.*);

/* sim/tb_trace_set_header_tlv_parser.sv */
`timescale 1ns / 100ps
// Self-checking testbench for trace_set_header_tlv_parser: a directed table and random header
// streams go in one byte per word, and every result word is checked field by field.
// Depends on tshtlv_pkg and the parser RTL; the expected words come from a parser model below.
module tb_trace_set_header_tlv_parser;
  import tshtlv_pkg::*;

  localparam int unsigned N_RANDOM = 1000;
  localparam int unsigned IDLE_PCT = 19;
  localparam int unsigned MAX_PRINTED = 40;
  localparam logic [7:0] LONG_LEN_FLAG = 8'h80;
  localparam logic [4:0] ALL_SEEN = 5'h1F;

  typedef enum logic [1:0] {AT_TAG, AT_LEN, AT_LEN_EXT, AT_VALUE} parse_at_t;
  typedef enum logic [1:0] {F_BAD_TAG, F_LEN_BYTES, F_NUM_LEN, F_OVER_MAX} fault_t;

  typedef struct packed {
    logic [7:0] b;
    logic       st;
    logic       typed;
    logic [7:0] tag;
    status_t    code;
  } stim_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] value;
    logic [7:0]  len;
    logic        done;
    status_t     status;
    logic [31:0] tlen;
    logic [31:0] count;
    logic [31:0] samples;
    logic [7:0]  coding;
    logic [31:0] title;
    logic [31:0] data;
  } hdr_word_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // data_byte
  logic [0:0]   s_axis_tuser;   // start_flag
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // record_tag, record_value, record_length, bytes_per_trace, trace_count,
  // samples_per_trace, sample_format, title_bytes, crypto_data_bytes
  logic [215:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;   // header_done, status

  trace_set_header_tlv_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  parse_at_t   parse_at;
  logic [7:0]  cur_tag;
  logic [6:0]  len_left;
  logic [31:0] len_acc;
  logic [7:0]  val_left;
  logic [7:0]  byte_idx;
  logic [31:0] val_acc;
  logic [31:0] cnt_cap;
  logic [31:0] smp_cap;
  logic [7:0]  cod_cap;
  logic [31:0] ttl_cap;
  logic [31:0] dat_cap;
  logic [4:0]  seen_tags;
  logic        halted;

  hdr_word_t   want_q[$];
  stim_t       stim_q[$];
  int unsigned n_bad = 0;
  bit          no_idle = 1'b0;

  stim_t dir_tab [25] = '{
    '{8'h76,       1'b1, 1'b1, 8'h76,     ST_BAD_TAG},
    '{8'h00,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{TAG_TRACES,  1'b1, 1'b0, 8'h00,     ST_OK},
    '{8'h84,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'h04,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'h00,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'h00,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'h00,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'hFF,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'hFF,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'hFF,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'hFF,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{TAG_MAX,     1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'h80,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{TAG_END,     1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'h00,       1'b0, 1'b1, TAG_END,   ST_MISSING},
    '{8'hFF,       1'b1, 1'b1, 8'hFF,     ST_BAD_TAG},
    '{TAG_CODING,  1'b1, 1'b0, 8'h00,     ST_OK},
    '{8'h85,       1'b0, 1'b1, TAG_CODING, ST_BAD_LEN},
    '{TAG_DATA,    1'b1, 1'b0, 8'h00,     ST_OK},
    '{8'h05,       1'b0, 1'b1, TAG_DATA,  ST_BAD_LEN},
    '{TAG_STR2,    1'b1, 1'b0, 8'h00,     ST_OK},
    '{8'h82,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'h00,       1'b0, 1'b0, 8'h00,     ST_OK},
    '{8'h01,       1'b0, 1'b1, TAG_STR2,  ST_BAD_LEN}
  };

  function automatic logic is_text_tag(input logic [7:0] tag);
    return tag == TAG_STR0 || tag == TAG_STR1 || tag == TAG_STR2 || tag == TAG_STR3 ||
           tag == TAG_BYTES;
  endfunction

  function automatic hdr_word_t make_word(input logic [7:0] tag, input logic [31:0] value,
                                          input logic [7:0] len, input logic done,
                                          input status_t status, input logic [31:0] tlen);
    hdr_word_t w;
    w.tag = tag;
    w.value = value;
    w.len = len;
    w.done = done;
    w.status = status;
    w.tlen = tlen;
    w.count = cnt_cap;
    w.samples = smp_cap;
    w.coding = cod_cap;
    w.title = ttl_cap;
    w.data = dat_cap;
    return w;
  endfunction

  task automatic clear_parser();
    parse_at = AT_TAG;
    cur_tag = '0;
    len_left = '0;
    len_acc = '0;
    val_left = '0;
    byte_idx = '0;
    val_acc = '0;
    cnt_cap = '0;
    smp_cap = '0;
    cod_cap = '0;
    ttl_cap = '0;
    dat_cap = '0;
    seen_tags = '0;
    halted = 1'b0;
  endtask

  task automatic stop_parse(input logic [7:0] tag, input status_t code,
                            output logic got, output hdr_word_t w);
    halted = 1'b1;
    parse_at = AT_TAG;
    got = 1'b1;
    w = make_word(tag, '0, '0, 1'b1, code, '0);
  endtask

  task automatic close_record(output logic got, output hdr_word_t w);
    logic [31:0] value;
    logic [31:0] tlen;
    status_t     code;
    value = is_text_tag(cur_tag) ? '0 : val_acc;
    tlen = '0;
    code = ST_OK;
    case (cur_tag)
      TAG_TRACES: begin
        cnt_cap = value;
        seen_tags[0] = 1'b1;
      end
      TAG_SAMPLES: begin
        smp_cap = value;
        seen_tags[1] = 1'b1;
      end
      TAG_CODING: begin
        cod_cap = value[7:0];
        seen_tags[2] = 1'b1;
      end
      TAG_DATA: begin
        dat_cap = value;
        seen_tags[3] = 1'b1;
      end
      TAG_TITLE: begin
        ttl_cap = value;
        seen_tags[4] = 1'b1;
      end
      default: ;
    endcase
    parse_at = AT_TAG;
    if (cur_tag == TAG_END) begin
      halted = 1'b1;
      if (seen_tags == ALL_SEEN) tlen = smp_cap * 32'(cod_cap[3:0]) + dat_cap + ttl_cap;
      else code = ST_MISSING;
    end
    got = 1'b1;
    w = make_word(cur_tag, value, len_acc[7:0], cur_tag == TAG_END, code, tlen);
  endtask

  task automatic open_value(input logic [31:0] len, output logic got, output hdr_word_t w);
    got = 1'b0;
    w = '0;
    len_acc = len;
    if (len > MAX_VALUE_LEN || (!is_text_tag(cur_tag) && len > MAX_NUM_BYTES)) begin
      stop_parse(cur_tag, ST_BAD_LEN, got, w);
    end else begin
      val_acc = '0;
      byte_idx = '0;
      if (len == 0) begin
        close_record(got, w);
      end else begin
        val_left = 8'(len);
        parse_at = AT_VALUE;
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic st,
                            output logic got, output hdr_word_t w);
    got = 1'b0;
    w = '0;
    if (st) clear_parser();
    if (halted) return;
    case (parse_at)
      AT_TAG: begin
        if (b > TAG_MAX) begin
          stop_parse(b, ST_BAD_TAG, got, w);
        end else begin
          cur_tag = b;
          parse_at = AT_LEN;
        end
      end
      AT_LEN: begin
        if (!b[7]) begin
          open_value(32'(b), got, w);
        end else if (b[6:0] > MAX_NUM_BYTES) begin
          stop_parse(cur_tag, ST_BAD_LEN, got, w);
        end else if (b[6:0] == 0) begin
          open_value('0, got, w);
        end else begin
          len_left = b[6:0];
          len_acc = '0;
          byte_idx = '0;
          parse_at = AT_LEN_EXT;
        end
      end
      AT_LEN_EXT: begin
        if (byte_idx < MAX_NUM_BYTES) len_acc |= 32'(b) << (8 * byte_idx);
        byte_idx++;
        len_left--;
        if (len_left == 0) open_value(len_acc, got, w);
      end
      default: begin
        if (byte_idx < MAX_NUM_BYTES) val_acc |= 32'(b) << (8 * byte_idx);
        byte_idx++;
        val_left--;
        if (val_left == 0) close_record(got, w);
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic st);
    stim_q.push_back('{b, st, 1'b0, 8'h00, ST_OK});
  endtask

  task automatic add_record(input logic [7:0] tag, input int unsigned len, input logic first);
    int unsigned n;
    push_byte(tag, first);
    if (len < 128 && $urandom_range(3) != 0) begin
      push_byte(8'(len), 1'b0);
    end else begin
      if (len == 0) n = $urandom_range(4, 0);
      else if (len < 256) n = $urandom_range(4, 1);
      else n = $urandom_range(4, 2);
      push_byte(LONG_LEN_FLAG | 8'(n), 1'b0);
      for (int i = 0; i < n; i++) push_byte(8'(len >> (8 * i)), 1'b0);
    end
    for (int i = 0; i < len; i++) push_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic add_broken(input logic first);
    fault_t      kind;
    int unsigned n;
    kind = fault_t'($urandom_range(3));
    case (kind)
      F_BAD_TAG: push_byte(8'($urandom_range(255, TAG_MAX + 1)), first);
      F_LEN_BYTES: begin
        push_byte(8'($urandom_range(TAG_MAX)), first);
        push_byte(8'($urandom_range(255, LONG_LEN_FLAG + MAX_NUM_BYTES + 1)), 1'b0);
      end
      F_NUM_LEN: begin
        push_byte(8'(TAG_TRACES + $urandom_range(4)), first);
        push_byte(8'($urandom_range(127, MAX_NUM_BYTES + 1)), 1'b0);
      end
      default: begin
        push_byte(TAG_BYTES, first);
        n = $urandom_range(4, 2);
        push_byte(LONG_LEN_FLAG | 8'(n), 1'b0);
        for (int i = 0; i < n - 1; i++) push_byte(8'($urandom_range(255)), 1'b0);
        push_byte(8'($urandom_range(255, 1)), 1'b0);
      end
    endcase
    repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic add_header();
    logic [7:0]  tags[$];
    logic [7:0]  tmp;
    logic [7:0]  tag;
    int unsigned j;
    int unsigned len;
    int unsigned err_at;
    int unsigned cut_at;
    logic        first;
    tags = '{TAG_TRACES, TAG_SAMPLES, TAG_CODING, TAG_DATA, TAG_TITLE};
    repeat ($urandom_range(3)) begin
      case ($urandom_range(5))
        0: tags.push_back(TAG_STR0);
        1: tags.push_back(TAG_STR1);
        2: tags.push_back(TAG_STR2);
        3: tags.push_back(TAG_STR3);
        4: tags.push_back(TAG_BYTES);
        default: tags.push_back(8'($urandom_range(TAG_MAX)));
      endcase
    end
    for (int i = tags.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = tags[i];
      tags[i] = tags[j];
      tags[j] = tmp;
    end
    err_at = ($urandom_range(9) == 0) ? $urandom_range(tags.size()) : 999;
    cut_at = ($urandom_range(19) == 0) ? $urandom_range(tags.size()) : 999;
    first = 1'b1;
    for (int i = 0; i <= tags.size(); i++) begin
      if (i == err_at) begin
        add_broken(first);
        return;
      end
      if (i == cut_at) begin
        push_byte(8'($urandom_range(TAG_MAX)), first);
        if ($urandom_range(1)) push_byte(LONG_LEN_FLAG | 8'(MAX_NUM_BYTES), 1'b0);
        return;
      end
      if (i == tags.size()) begin
        add_record(TAG_END, ($urandom_range(4) == 0) ? $urandom_range(4, 1) : 0, first);
      end else begin
        tag = tags[i];
        if (tag >= TAG_TRACES && tag <= TAG_TITLE && $urandom_range(14) == 0) continue;
        if (is_text_tag(tag))
          len = ($urandom_range(39) == 0) ? $urandom_range(MAX_VALUE_LEN, 128)
                                          : $urandom_range(12);
        else if (tag == TAG_CODING && $urandom_range(1))
          len = 1;
        else
          len = $urandom_range(MAX_NUM_BYTES);
        add_record(tag, len, first);
      end
      first = 1'b0;
    end
    repeat ($urandom_range(2)) push_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic add_noise();
    repeat ($urandom_range(20, 5))
      push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  task automatic send_byte(input stim_t s);
    logic      got;
    hdr_word_t w;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s.b;
    s_axis_tuser <= s.st;
    do @(posedge clk); while (!s_axis_tready);
    parse_byte(s.b, s.st, got, w);
    if (s.typed) begin
      got = 1'b1;
      w.tag = s.tag;
      w.value = '0;
      w.len = '0;
      w.done = 1'b1;
      w.status = s.code;
      w.tlen = '0;
    end
    if (got) want_q.push_back(w);
  endtask

  task automatic report_mismatch(input string what);
    n_bad++;
    if (n_bad <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] seen, input logic [31:0] want);
    if (seen !== want) report_mismatch($sformatf("%s is %h, expected %h", name, seen, want));
  endtask

  always @(negedge clk) m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin : check_words
    hdr_word_t w;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (want_q.size() == 0) begin
        report_mismatch($sformatf("word with tag %h arrived with nothing pending",
                                  m_axis_tdata[7:0]));
      end else begin
        w = want_q.pop_front();
        cmp_field("record_tag", 32'(m_axis_tdata[7:0]), 32'(w.tag));
        cmp_field("record_value", m_axis_tdata[39:8], w.value);
        cmp_field("record_length", 32'(m_axis_tdata[47:40]), 32'(w.len));
        cmp_field("bytes_per_trace", m_axis_tdata[79:48], w.tlen);
        cmp_field("trace_count", m_axis_tdata[111:80], w.count);
        cmp_field("samples_per_trace", m_axis_tdata[143:112], w.samples);
        cmp_field("sample_format", 32'(m_axis_tdata[151:144]), 32'(w.coding));
        cmp_field("title_bytes", m_axis_tdata[183:152], w.title);
        cmp_field("crypto_data_bytes", m_axis_tdata[215:184], w.data);
        cmp_field("header_done", 32'(m_axis_tuser[0]), 32'(w.done));
        cmp_field("status", 32'(m_axis_tuser[2:1]), 32'(w.status));
      end
    end
  end

  initial begin
    int unsigned guard;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    clear_parser();
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (dir_tab[i]) send_byte(dir_tab[i]);

    while (stim_q.size() < N_RANDOM) begin
      if ($urandom_range(19) == 0) add_noise();
      else add_header();
    end
    foreach (stim_q[i]) begin
      no_idle = (i >= 400 && i < 600);
      send_byte(stim_q[i]);
    end
    no_idle = 1'b0;
    @(negedge clk) s_axis_tvalid <= 1'b0;

    guard = 0;
    while (want_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (want_q.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", want_q.size()));
    if (n_bad == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
hdl/tshtlv_pkg.sv
hdl/tshtlv_core.sv
hdl/trace_set_header_tlv_parser.sv
hdl/tshtlv_checker.sv
sim/tb_trace_set_header_tlv_parser.sv
